FILE: rtl/bfd_pkg.sv
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared constants, types and the reciprocal table of the box filter
// downsampler.
// ----------------------------------------------------------------------------
package bfd_pkg;

    localparam int MAX_OUT_WIDTH = 1024;
    localparam int MAX_FACTOR    = 4;
    localparam int HEIGHT_LIMIT  = 4096;

    // register widths
    localparam int OW_W  = 11;
    localparam int OH_W  = 13;
    localparam int AA_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // payload widths
    localparam int PIX_W  = 8;
    localparam int OCOL_W = 10;
    localparam int OROW_W = 12;

    // counter widths
    localparam int SUB_W  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int FACT_W = $clog2(MAX_FACTOR + 1);
    localparam int COL_W  = $clog2(MAX_OUT_WIDTH);
    localparam int WEFF_W = $clog2(MAX_OUT_WIDTH + 1);
    localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
    localparam int HEFF_W = $clog2(HEIGHT_LIMIT + 1);

    // channel sums
    localparam int SUM_CAP = 255 * MAX_FACTOR * MAX_FACTOR;
    localparam int SUM_W   = $clog2(SUM_CAP + 1);
    localparam int NUM_LANES = 3;
    localparam int LINE_W  = NUM_LANES * SUM_W;

    // reciprocal of the block area, scaled by 2**RECIP_SH
    localparam int RECIP_SH = 20;
    localparam int RECIP_W  = RECIP_SH + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUT_WIDTH  = 2'd0,
        CFG_OUT_HEIGHT = 2'd1,
        CFG_AA_FACTOR  = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic calc;
        logic first;
    } t_lane_ctrl;

    // ceil(2**20 / (f*f)); exact enough for every sum up to 255*f*f
    function automatic logic [RECIP_W-1:0] recip_of(input logic [3:0] f);
        logic [RECIP_W-1:0] r;
        case (f)
            4'd1:    r = RECIP_W'(1048576);
            4'd2:    r = RECIP_W'(262144);
            4'd3:    r = RECIP_W'(116509);
            4'd4:    r = RECIP_W'(65536);
            4'd5:    r = RECIP_W'(41944);
            4'd6:    r = RECIP_W'(29128);
            4'd7:    r = RECIP_W'(21400);
            4'd8:    r = RECIP_W'(16384);
            default: r = RECIP_W'(1048576);
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/bfd_if.sv
// ----------------------------------------------------------------------------
// bfd_if
// Valid/ready channels of the box filter downsampler: pixel in, result out,
// configuration write.
// ----------------------------------------------------------------------------
interface bfd_pix_if import bfd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             start_frame;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;

    modport source (output valid, start_frame, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, start_frame, red_in, green_in, blue_in, output ready);
endinterface

interface bfd_res_if import bfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  red_out;
    logic [PIX_W-1:0]  green_out;
    logic [PIX_W-1:0]  blue_out;
    logic [OCOL_W-1:0] out_column;
    logic [OROW_W-1:0] out_row;
    logic              frame_done;

    modport source (output valid, red_out, green_out, blue_out, out_column, out_row,
                    frame_done, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, out_column, out_row,
                    frame_done, output ready);
endinterface

interface bfd_cfg_if import bfd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/box_filter_downsample.sv
// ----------------------------------------------------------------------------
// box_filter_downsample
// A block's last pixel passes S_READ and S_CALC; in S_EMIT its result is registered,
// waiting while an earlier result is held. A new pixel is taken only in S_IDLE, once
// the read-modify-write of the column sum line memory (read, add, divide) is done.
// Reset clears the block and row counters and the registers to their defaults;
// the line memory is not cleared, the first pixel of each block writes it.
// ----------------------------------------------------------------------------
module box_filter_downsample import bfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfd_pix_if.sink    i_pix,
    bfd_res_if.source  o_res,
    bfd_cfg_if.sink    i_cfg
);

    // configuration
    logic [OW_W-1:0] r_out_width;
    logic [OH_W-1:0] r_out_height;
    logic [AA_W-1:0] r_aa_factor;

    logic [FACT_W-1:0] f_eff;
    logic [WEFF_W-1:0] w_eff;
    logic [HEFF_W-1:0] h_eff;

    // frame counters
    logic [SUB_W-1:0] r_sub_col, n_sub_col, cur_sub_col;
    logic [COL_W-1:0] r_col_idx, n_col_idx, cur_col_idx;
    logic [SUB_W-1:0] r_sub_row, n_sub_row, cur_sub_row;
    logic [ROW_W-1:0] r_row_idx, n_row_idx, cur_row_idx;

    logic [FACT_W-1:0] sc_inc;
    logic [FACT_W-1:0] sr_inc;
    logic [WEFF_W-1:0] col_inc;
    logic [HEFF_W-1:0] row_inc;

    // item in flight
    t_state            r_state, n_state;
    logic [COL_W-1:0]  r_col;
    logic              r_first;
    logic              r_last;
    logic [OCOL_W-1:0] r_ocol;
    logic [OROW_W-1:0] r_orow;
    logic              r_fdone;

    // result register
    logic              r_ovalid;
    logic [PIX_W-1:0]  r_red, r_green, r_blue;
    logic [OCOL_W-1:0] r_res_col;
    logic [OROW_W-1:0] r_res_row;
    logic              r_res_fdone;

    logic in_acc;
    logic cfg_acc;
    logic res_load;
    logic mem_we;

    t_lane_ctrl         lane_ctrl;
    logic [RECIP_W-1:0] recip;
    logic [LINE_W-1:0]  line_rd;
    logic [LINE_W-1:0]  line_wr;
    logic [PIX_W-1:0]   lane_px  [NUM_LANES];
    logic [PIX_W-1:0]   lane_avg [NUM_LANES];

    assign in_acc  = i_pix.valid & i_pix.ready;
    assign cfg_acc = i_cfg.valid & i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width  <= OW_W'(1024);
            r_out_height <= OH_W'(4096);
            r_aa_factor  <= AA_W'(2);
        end else if (cfg_acc) begin
            case (i_cfg.index)
                CFG_OUT_WIDTH:  r_out_width  <= i_cfg.data[OW_W-1:0];
                CFG_OUT_HEIGHT: r_out_height <= i_cfg.data[OH_W-1:0];
                CFG_AA_FACTOR:  r_aa_factor  <= i_cfg.data[AA_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp registers to their usable ranges
    always_comb begin
        if (r_aa_factor == '0) begin
            f_eff = FACT_W'(1);
        end else if (int'(r_aa_factor) > MAX_FACTOR) begin
            f_eff = FACT_W'(MAX_FACTOR);
        end else begin
            f_eff = FACT_W'(r_aa_factor);
        end

        if (r_out_width == '0) begin
            w_eff = WEFF_W'(1);
        end else if (int'(r_out_width) > MAX_OUT_WIDTH) begin
            w_eff = WEFF_W'(MAX_OUT_WIDTH);
        end else begin
            w_eff = WEFF_W'(r_out_width);
        end

        if (r_out_height == '0) begin
            h_eff = HEFF_W'(1);
        end else if (int'(r_out_height) > HEIGHT_LIMIT) begin
            h_eff = HEFF_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = HEFF_W'(r_out_height);
        end
    end

    // counters as seen by the incoming item, and their advance
    always_comb begin
        if (i_pix.start_frame) begin
            cur_sub_col = '0;
            cur_col_idx = '0;
            cur_sub_row = '0;
            cur_row_idx = '0;
        end else begin
            cur_sub_col = r_sub_col;
            cur_col_idx = r_col_idx;
            cur_sub_row = r_sub_row;
            cur_row_idx = r_row_idx;
        end

        sc_inc  = FACT_W'(cur_sub_col) + FACT_W'(1);
        sr_inc  = FACT_W'(cur_sub_row) + FACT_W'(1);
        col_inc = WEFF_W'(cur_col_idx) + WEFF_W'(1);
        row_inc = HEFF_W'(cur_row_idx) + HEFF_W'(1);

        n_sub_col = cur_sub_col;
        n_col_idx = cur_col_idx;
        n_sub_row = cur_sub_row;
        n_row_idx = cur_row_idx;

        if (sc_inc >= f_eff) begin
            n_sub_col = '0;
            if (col_inc >= w_eff) begin
                n_col_idx = '0;
                if (sr_inc >= f_eff) begin
                    n_sub_row = '0;
                    if (row_inc >= h_eff) begin
                        n_row_idx = '0;
                    end else begin
                        n_row_idx = row_inc[ROW_W-1:0];
                    end
                end else begin
                    n_sub_row = sr_inc[SUB_W-1:0];
                end
            end else begin
                n_col_idx = col_inc[COL_W-1:0];
            end
        end else begin
            n_sub_col = sc_inc[SUB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_col <= '0;
            r_col_idx <= '0;
            r_sub_row <= '0;
            r_row_idx <= '0;
        end else if (in_acc) begin
            r_sub_col <= n_sub_col;
            r_col_idx <= n_col_idx;
            r_sub_row <= n_sub_row;
            r_row_idx <= n_row_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_col   <= cur_col_idx;
            r_first <= (cur_sub_col == '0) && (cur_sub_row == '0);
            r_last  <= (FACT_W'(cur_sub_col) == f_eff - FACT_W'(1)) &&
                       (FACT_W'(cur_sub_row) == f_eff - FACT_W'(1));
            r_ocol  <= OCOL_W'(cur_col_idx);
            r_orow  <= OROW_W'(cur_row_idx);
            r_fdone <= (WEFF_W'(cur_col_idx) == w_eff - WEFF_W'(1)) &&
                       (HEFF_W'(cur_row_idx) == h_eff - HEFF_W'(1));
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        res_load = 1'b0;
        mem_we   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                mem_we  = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!r_ovalid || o_res.ready) begin
                    res_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // line memory of per-column channel sums
    bfd_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_col),
        .i_wdata (line_wr),
        .i_raddr (r_col),
        .o_rdata (line_rd)
    );

    assign lane_ctrl.load  = in_acc;
    assign lane_ctrl.calc  = (r_state == S_CALC);
    assign lane_ctrl.first = r_first;
    assign recip = recip_of(4'(f_eff));

    assign lane_px[0] = i_pix.red_in;
    assign lane_px[1] = i_pix.green_in;
    assign lane_px[2] = i_pix.blue_in;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        bfd_lane u_lane (
            .i_clk    (i_clk),
            .i_ctrl   (lane_ctrl),
            .i_px     (lane_px[g]),
            .i_rd_sum (line_rd[g*SUM_W +: SUM_W]),
            .i_recip  (recip),
            .o_wr_sum (line_wr[g*SUM_W +: SUM_W]),
            .o_avg    (lane_avg[g])
        );
    end

    // merge lane averages with the block coordinates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_load) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_red       <= lane_avg[0];
            r_green     <= lane_avg[1];
            r_blue      <= lane_avg[2];
            r_res_col   <= r_ocol;
            r_res_row   <= r_orow;
            r_res_fdone <= r_fdone;
        end
    end

    assign o_res.valid      = r_ovalid;
    assign o_res.red_out    = r_red;
    assign o_res.green_out  = r_green;
    assign o_res.blue_out   = r_blue;
    assign o_res.out_column = r_res_col;
    assign o_res.out_row    = r_res_row;
    assign o_res.frame_done = r_res_fdone;

    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_READ))
        else $error("accepted item did not start a line read");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> ($past(r_state) == S_EMIT && $past(r_last)))
        else $error("result shown without a finished block");

    a_write_once_per_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ($past(r_state, 2) == S_IDLE && !i_pix.ready))
        else $error("line write outside an item's sequence");

    a_frame_done_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_done) |->
            (WEFF_W'(o_res.out_column) == w_eff - WEFF_W'(1)))
        else $error("frame end flagged away from the last column");

endmodule

FILE: rtl/bfd_ram.sv
// ----------------------------------------------------------------------------
// bfd_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module bfd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bfd_lane.sv
// ----------------------------------------------------------------------------
// bfd_lane
// One color channel: holds the pixel sample, accumulates it into the column
// sum with saturation and divides the block sum by the block area.
// ----------------------------------------------------------------------------
module bfd_lane import bfd_pkg::*; (
    input  logic               i_clk,
    input  t_lane_ctrl         i_ctrl,
    input  logic [PIX_W-1:0]   i_px,
    input  logic [SUM_W-1:0]   i_rd_sum,
    input  logic [RECIP_W-1:0] i_recip,
    output logic [SUM_W-1:0]   o_wr_sum,
    output logic [PIX_W-1:0]   o_avg
);

    localparam int PROD_W = SUM_W + RECIP_W;
    localparam int QUOT_W = PROD_W - RECIP_SH;

    logic [PIX_W-1:0]  r_px;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W:0]    add_sum;
    logic [SUM_W-1:0]  n_sum;
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;

    always_comb begin
        add_sum = {1'b0, i_rd_sum} + (SUM_W + 1)'(r_px);
        if (i_ctrl.first) begin
            n_sum = SUM_W'(r_px);
        end else if (add_sum > (SUM_W + 1)'(SUM_CAP)) begin
            n_sum = SUM_W'(SUM_CAP);
        end else begin
            n_sum = add_sum[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_px <= i_px;
        end
        if (i_ctrl.calc) begin
            r_sum <= n_sum;
        end
    end

    // divide by the area as a multiply by its scaled reciprocal
    always_comb begin
        prod = PROD_W'(r_sum) * PROD_W'(i_recip);
        quot = prod[PROD_W-1:RECIP_SH];
        if (quot > QUOT_W'(255)) begin
            o_avg = PIX_W'(255);
        end else begin
            o_avg = quot[PIX_W-1:0];
        end
    end

    assign o_wr_sum = n_sum;

endmodule

FILE: verif/bfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_checker
// Watches the pixel, result and register channels of the box filter
// downsampler, predicts each block average from the accepted pixels and
// compares every accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bfd_checker import bfd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bfd_pix_if   i_pix,
    bfd_res_if   i_res,
    bfd_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int RESET_FACTOR = 2;
    localparam int PRINT_CAP    = 60;

    typedef struct packed {
        logic [PIX_W-1:0]  red;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  blue;
        logic [OCOL_W-1:0] column;
        logic [OROW_W-1:0] row;
        logic              frame_done;
    } t_block_avg;

    logic [OW_W-1:0] width_reg;
    logic [OH_W-1:0] height_reg;
    logic [AA_W-1:0] factor_reg;

    int unsigned line_sum [MAX_OUT_WIDTH][NUM_LANES];
    int unsigned sub_col;
    int unsigned col_idx;
    int unsigned sub_row;
    int unsigned row_idx;
    t_block_avg  avg_q[$];

    int fail_count  = 0;
    int pending_cnt = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] lane_avg(input int unsigned sum,
                                                  input int unsigned area);
        int unsigned q;
        q = sum / area;
        return (q > 255) ? '1 : PIX_W'(q);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (fail_count < PRINT_CAP)
            $display("%0t: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic take_pixel(input logic sf, input logic [PIX_W-1:0] r, g, b);
        int unsigned f, w, h, col, acc, k;
        int unsigned px [NUM_LANES];
        t_block_avg  blk;
        f = clamp_to(factor_reg, MAX_FACTOR);
        w = clamp_to(width_reg, MAX_OUT_WIDTH);
        h = clamp_to(height_reg, HEIGHT_LIMIT);
        px[0] = r;
        px[1] = g;
        px[2] = b;
        if (sf) begin
            sub_col = 0;
            col_idx = 0;
            sub_row = 0;
            row_idx = 0;
        end
        col = col_idx % MAX_OUT_WIDTH;
        // first pixel of a block overwrites, the rest accumulate
        for (k = 0; k < NUM_LANES; k++) begin
            if (sub_col == 0 && sub_row == 0) begin
                line_sum[col][k] = px[k];
            end else begin
                acc = line_sum[col][k] + px[k];
                line_sum[col][k] = (acc > SUM_CAP) ? SUM_CAP : acc;
            end
        end
        if (sub_col == f - 1 && sub_row == f - 1) begin
            blk.red        = lane_avg(line_sum[col][0], f * f);
            blk.green      = lane_avg(line_sum[col][1], f * f);
            blk.blue       = lane_avg(line_sum[col][2], f * f);
            blk.column     = OCOL_W'(col_idx);
            blk.row        = OROW_W'(row_idx);
            blk.frame_done = (col_idx == w - 1) && (row_idx == h - 1);
            avg_q.push_back(blk);
        end
        // counters at or above a lowered limit wrap on their next step
        sub_col++;
        if (sub_col >= f) begin
            sub_col = 0;
            col_idx++;
            if (col_idx >= w) begin
                col_idx = 0;
                sub_row++;
                if (sub_row >= f) begin
                    sub_row = 0;
                    row_idx++;
                    if (row_idx >= h) row_idx = 0;
                end
            end
        end
    endtask

    task automatic check_result();
        t_block_avg want;
        if (avg_q.size() == 0) begin
            report_mismatch("result with no block pending, out_column", i_res.out_column, 0);
            return;
        end
        want = avg_q.pop_front();
        if (i_res.red_out != want.red)
            report_mismatch("red_out", i_res.red_out, want.red);
        if (i_res.green_out != want.green)
            report_mismatch("green_out", i_res.green_out, want.green);
        if (i_res.blue_out != want.blue)
            report_mismatch("blue_out", i_res.blue_out, want.blue);
        if (i_res.out_column != want.column)
            report_mismatch("out_column", i_res.out_column, want.column);
        if (i_res.out_row != want.row)
            report_mismatch("out_row", i_res.out_row, want.row);
        if (i_res.frame_done != want.frame_done)
            report_mismatch("frame_done", i_res.frame_done, want.frame_done);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = OW_W'(MAX_OUT_WIDTH);
            height_reg = OH_W'(HEIGHT_LIMIT);
            factor_reg = AA_W'(RESET_FACTOR);
            sub_col    = 0;
            col_idx    = 0;
            sub_row    = 0;
            row_idx    = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_OUT_WIDTH:  width_reg  = i_cfg.data[OW_W-1:0];
                    CFG_OUT_HEIGHT: height_reg = i_cfg.data[OH_W-1:0];
                    CFG_AA_FACTOR:  factor_reg = i_cfg.data[AA_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready)
                take_pixel(i_pix.start_frame, i_pix.red_in, i_pix.green_in, i_pix.blue_in);
            if (i_res.valid && i_res.ready)
                check_result();
        end
        pending_cnt = avg_q.size();
    end

endmodule

FILE: verif/tb_box_filter_downsample.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_filter_downsample
// Drives pixels and register writes into the box filter downsampler: a
// full-width line, short directed blocks for the range and mid-frame cases,
// then random frames under changing sender and receiver idling, one long
// receiver hold-off included. The checker judges every result.
// ----------------------------------------------------------------------------
module tb_box_filter_downsample;
    import bfd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int PIX_COUNT    = 560;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 12;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_go       = 1'b0;
    int unsigned frame_left = 0;

    bfd_pix_if pix ();
    bfd_res_if res ();
    bfd_cfg_if cfg ();

    box_filter_downsample dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    bfd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix),
        .i_res        (res),
        .i_cfg        (cfg),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    // result side: random stalls, or a long hold-off when asked
    initial begin
        int   hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                res.ready <= 1'b0;
                hold_left--;
            end else if (hold_go != hold_seen) begin
                hold_seen = hold_go;
                hold_left = HOLD_CYCLES;
                res.ready <= 1'b0;
            end else begin
                res.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    function automatic logic [PIX_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // valid stays high after the accept edge; the next call or a gap moves it
    task automatic send_pixel(input logic sf, input logic [PIX_W-1:0] r, g, b);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            pix.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        pix.valid       <= 1'b1;
        pix.start_frame <= sf;
        pix.red_in      <= r;
        pix.green_in    <= g;
        pix.blue_in     <= b;
        do @(negedge i_clk); while (!pix.ready);
        @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(negedge i_clk); while (!cfg.ready);
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        pix.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        // items that make no result may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input int unsigned w, h, f);
        logic [CFG_DATA_W-1:0] d;
        wait_drained();
        d = CFG_DATA_W'($urandom);
        d[OW_W-1:0] = OW_W'(w);
        put_reg(CFG_OUT_WIDTH, d);
        put_reg(CFG_OUT_HEIGHT, CFG_DATA_W'(h));
        d = CFG_DATA_W'($urandom);
        d[AA_W-1:0] = AA_W'(f);
        put_reg(CFG_AA_FACTOR, d);
        put_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        cfg.valid <= 1'b0;
    endtask

    // raster frames of random content, with a few stray frame starts
    task automatic random_frames(input int n_items, input int unsigned w, h, f,
                                 input bit fresh);
        int unsigned ef, frame_len;
        int          i;
        logic        sf;
        ef = clamp_to(f, MAX_FACTOR);
        frame_len = clamp_to(w, MAX_OUT_WIDTH) * ef * clamp_to(h, HEIGHT_LIMIT) * ef;
        if (fresh) frame_left = 0;
        else frame_left = $urandom_range(1, frame_len);
        for (i = 0; i < n_items; i++) begin
            sf = (frame_left == 0) || ($urandom_range(0, 99) < 2);
            if (sf) frame_left = frame_len;
            frame_left--;
            send_pixel(sf, pick_level(), pick_level(), pick_level());
        end
    endtask

    initial begin
        int          i, n, items_left, phase, guard;
        int unsigned w, h, f;
        t_idle_mode  mode;

        i_rst_n         <= 1'b0;
        pix.valid       <= 1'b0;
        pix.start_frame <= 1'b0;
        pix.red_in      <= '0;
        pix.green_in    <= '0;
        pix.blue_in     <= '0;
        cfg.valid       <= 1'b0;
        cfg.index       <= CFG_OUT_WIDTH;
        cfg.data        <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full-width line at factor zero (acts as one); writes every line-store entry
        set_config(MAX_OUT_WIDTH, 1, 0);
        for (i = 0; i < MAX_OUT_WIDTH; i++) begin
            case (i)
                0:       send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
                1:       send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
                2:       send_pixel(1'b0, 8'h55, 8'hAA, 8'h0F);
                default: send_pixel(1'b0, pick_level(), pick_level(), pick_level());
            endcase
        end

        // factor above range acts as the largest, all-white block
        set_config(1, 1, 7);
        for (i = 0; i < 16; i++) send_pixel(i == 0, 8'hFF, 8'hFF, 8'hFF);

        // zero width and height act as one
        set_config(0, 0, 2);
        for (i = 0; i < 4; i++) send_pixel(i == 0, 8'h00, 8'h80, 8'hFF);

        // factor lowered inside a block: oversized sum, saturated average
        set_config(1, 1, 4);
        for (i = 0; i < 5; i++) send_pixel(i == 0, 8'hFF, 8'hFE, 8'hFF);
        set_config(1, 1, 2);
        for (i = 0; i < 2; i++) send_pixel(1'b0, 8'hFF, 8'hFF, 8'h7F);

        // width and height above range, frame carries on without a start
        set_config(2047, 8191, 3);
        for (i = 0; i < 3; i++) send_pixel(1'b0, pick_level(), pick_level(), pick_level());

        items_left = PIX_COUNT;
        phase = 0;
        while (items_left > 0) begin
            case ($urandom_range(0, 19))
                0:       w = 0;
                1:       w = $urandom_range(MAX_OUT_WIDTH + 1, 2047);
                2:       w = MAX_OUT_WIDTH;
                3, 4:    w = $urandom_range(9, 64);
                default: w = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 9))
                0:       h = 0;
                1:       h = $urandom_range(HEIGHT_LIMIT + 1, 8191);
                2:       h = $urandom_range(5, HEIGHT_LIMIT);
                default: h = $urandom_range(1, 4);
            endcase
            case ($urandom_range(0, 9))
                0:       f = 0;
                1:       f = $urandom_range(MAX_FACTOR + 1, 7);
                default: f = $urandom_range(1, MAX_FACTOR);
            endcase
            n = $urandom_range(60, 140);
            if (phase == 0) begin
                // small frames with a result per pixel for the hold-off
                w = 3;
                h = 2;
                f = 1;
                n = 160;
            end
            if (n > items_left) n = items_left;
            set_config(w, h, f);

            mode = t_idle_mode'(phase % 4);
            case (mode)
                IDLE_NONE: begin
                    send_idle_pct = 0;
                    stall_pct <= 0;
                end
                IDLE_SENDER: begin
                    send_idle_pct = 82;
                    stall_pct <= 0;
                end
                IDLE_RECEIVER: begin
                    send_idle_pct = 0;
                    stall_pct <= 82;
                end
                default: begin
                    send_idle_pct = 37;
                    stall_pct <= 37;
                end
            endcase
            if (phase == 0) hold_go <= ~hold_go;

            random_frames(n, w, h, f, (phase == 0) || ($urandom_range(0, 3) != 0));
            items_left -= n;
            phase++;
        end

        pix.valid <= 1'b0;
        for (guard = 0; guard < 100000 && pending != 0; guard++) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending != 0) $display("%0d block results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
